>>> src/b64e_pkg.sv
// Shared types, constants and the sextet-to-character map of the base64 encoder.
package b64e_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } in_item_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } out_item_type;

   // One closed group: 24 bits, MSB byte first, number of '=' and message end.
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  pads;
      logic        last;
   } grp_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_stat_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         c = url ? 8'h2D : 8'h2B;
      end else begin
         c = url ? 8'h5F : 8'h2F;
      end
      return c;
   endfunction

endpackage

>>> src/b64e_front.sv
// Front end: gathers input bytes into groups of three and closes groups on last.
module b64e_front
   import b64e_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  in_item_type req_payload,
   input  q_stat_type  q_stat,
   output logic        push,
   output grp_type     push_grp
);

   logic [15:0] held_ff, held_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        two_held;

   assign accept   = req_valid && !q_stat.full;
   // a count of three cannot occur; it behaves as two
   assign two_held = count_ff[1];
   assign push     = accept && (two_held || req_payload.last_byte);

   always_comb begin
      held_in  = held_ff;
      count_in = count_ff;
      push_grp.last = req_payload.last_byte;
      if (two_held) begin
         push_grp.bits = {held_ff, req_payload.data_byte};
         push_grp.pads = 2'd0;
      end else if (count_ff[0]) begin
         push_grp.bits = {held_ff[7:0], req_payload.data_byte, 8'h00};
         push_grp.pads = 2'd1;
      end else begin
         push_grp.bits = {req_payload.data_byte, 16'h0000};
         push_grp.pads = 2'd2;
      end
      if (accept) begin
         if (push) begin
            held_in  = 16'h0000;
            count_in = 2'd0;
         end else begin
            held_in  = {held_ff[7:0], req_payload.data_byte};
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 16'h0000;
         count_ff <= 2'd0;
      end else begin
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/b64e_queue.sv
// Two-entry group queue between front end and character emitter.
module b64e_queue
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  grp_type    push_grp,
   input  logic       pop,
   output grp_type    head_grp,
   output q_stat_type q_stat
);

   grp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign q_stat.full  = (cnt_ff == 2'd2);
   assign q_stat.valid = (cnt_ff != 2'd0);
   assign head_grp     = mem_ff[rd_ptr_ff];
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && q_stat.valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_grp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> src/b64e_back.sv
// Back end: turns one group into four characters on a registered output.
module b64e_back
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_wdata,
   input  grp_type      head_grp,
   input  q_stat_type   q_stat,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output out_item_type rsp_payload
);

   logic         url_ff;
   grp_type      ent_ff, ent_in;
   logic         busy_ff, busy_in;
   logic [1:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   out_item_type rsp_item_ff, rsp_item_in;
   logic         slot_free, emit, done;
   logic [5:0]   sextet;
   logic         is_pad;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && slot_free;
   assign done      = emit && (idx_ff == 2'd3);
   assign pop       = q_stat.valid && (!busy_ff || done);

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = ent_ff.bits[23:18];
         2'd1:    sextet = ent_ff.bits[17:12];
         2'd2:    sextet = ent_ff.bits[11:6];
         default: sextet = ent_ff.bits[5:0];
      endcase
      // trailing characters with no input bits become pads
      is_pad = ({1'b0, idx_ff} + {1'b0, ent_ff.pads}) >= 3'd4;
   end

   always_comb begin
      ent_in       = pop ? head_grp : ent_ff;
      busy_in      = pop ? 1'b1 : (done ? 1'b0 : busy_ff);
      idx_in       = pop ? 2'd0 : (emit ? idx_ff + 2'd1 : idx_ff);
      rsp_valid_in = slot_free ? busy_ff : rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit) begin
         rsp_item_in.out_char  = is_pad ? PAD_CHAR : sextet_char(sextet, url_ff);
         rsp_item_in.last_char = (idx_ff == 2'd3) && ent_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         url_ff       <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            url_ff <= csr_wdata;
         end
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule

>>> src/base64_stream_encoder.sv
// The first character of a group passes the group queue, the back end's group register and
// its output register after the group's closing byte is taken. The emitter gives one
// character per cycle while the receiver does not stall, four per group, so bytes are taken
// in bursts of one per cycle while the two-entry group queue has room, and are held off once it is full.
// Reset (synchronous, active high) empties the group queue, drops held bytes and
// selects the standard alphabet.
module base64_stream_encoder
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  in_item_type  req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output out_item_type rsp_payload,
   input  logic         csr_we,
   input  logic         csr_wdata
);

   q_stat_type q_stat;
   logic       push, pop;
   grp_type    push_grp, head_grp;

   assign req_stall = q_stat.full;

   b64e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .q_stat      (q_stat),
      .push        (push),
      .push_grp    (push_grp)
   );

   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_grp (push_grp),
      .pop      (pop),
      .head_grp (head_grp),
      .q_stat   (q_stat)
   );

   b64e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .head_grp    (head_grp),
      .q_stat      (q_stat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> q_stat.valid)
      else $error("group queue full without a valid head");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall && !q_stat.valid)
      else $error("encoder not empty after reset");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.valid)
      else $error("group popped from empty queue");
`endif

endmodule

>>> verif/base64_stream_encoder_tb.sv
// Self-checking testbench for the base64 encoder: directed groups, alphabets, random traffic, back-pressure.
module base64_stream_encoder_tb
   import b64e_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;

   localparam string ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                 "abcdefghijklmnopqrstuvwxyz0123456789+/"};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   in_item_type  req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   out_item_type rsp_payload;
   logic         csr_we = 1'b0;
   logic         csr_wdata = 1'b0;

   base64_stream_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [15:0]  held_bytes;
   logic [1:0]   held_count;
   logic         url_alphabet;
   out_item_type expected_chars[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_req = 0;
   int hold_off_left = 0;
   int error_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   out_item_type want;

   function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
      logic [7:0] c;
      c = ALPHABET[v];
      if (url_alphabet && v == 6'd62) c = "-";
      if (url_alphabet && v == 6'd63) c = "_";
      return c;
   endfunction

   function automatic void push_group(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input int real_chars,
                                      input logic msg_end);
      logic [23:0]  bits;
      out_item_type ch;
      bits = {b0, b1, b2};
      for (int k = 0; k < 4; k++) begin
         ch.out_char = (k < real_chars) ? sextet_ascii(bits[23 - 6 * k -: 6]) : PAD_CHAR;
         ch.last_char = (k == 3) ? msg_end : 1'b0;
         expected_chars.push_back(ch);
      end
   endfunction

   function automatic void predict_encoding(input in_item_type it);
      if (held_count == 2'd2) begin
         push_group(held_bytes[15:8], held_bytes[7:0], it.data_byte, 4, it.last_byte);
         held_bytes = '0;
         held_count = '0;
      end else if (!it.last_byte) begin
         held_bytes = {held_bytes[7:0], it.data_byte};
         held_count = held_count + 2'd1;
      end else begin
         if (held_count == 2'd0)
            push_group(it.data_byte, 8'h00, 8'h00, 2, 1'b1);
         else
            push_group(held_bytes[7:0], it.data_byte, 8'h00, 3, 1'b1);
         held_bytes = '0;
         held_count = '0;
      end
   endfunction

   // receiver: random stall, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_off_req > 0) begin
         hold_off_left = hold_off_req;
         hold_off_req = 0;
      end
      rsp_stall <= (hold_off_left > 0) || ($urandom_range(0, 99) < rsp_stall_pct);
      if (hold_off_left > 0) hold_off_left--;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected item: out_char %h last_char %b",
                   rsp_payload.out_char, rsp_payload.last_char);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_payload.out_char !== want.out_char) begin
               $error("out_char: expected %h actual %h", want.out_char, rsp_payload.out_char);
               error_count++;
            end
            if (rsp_payload.last_char !== want.last_char) begin
               $error("last_char: expected %b actual %b", want.last_char,
                      rsp_payload.last_char);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL base64_stream_encoder");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic msg_end);
      in_item_type it;
      it.data_byte = b;
      it.last_byte = msg_end;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall);
      predict_encoding(it);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_alphabet(input logic url);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= url;
      @(posedge clock);
      url_alphabet = url;
      csr_we <= 1'b0;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
   endtask

   task automatic test_directed_groups();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      // sextets 62 63 62 63
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      // full group then one byte padded
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_url_alphabet();
      set_alphabet(1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b1);
      set_alphabet(1'b0);
   endtask

   task automatic run_random_phase(input int n_items, input int idle, input int stall);
      int target;
      int len;
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      target = items_sent + n_items;
      while (items_sent < target) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 7);
         send_message(len);
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(70, 0, 0);
      set_alphabet(1'b1);
      run_random_phase(70, 88, 0);
      set_alphabet(1'b0);
      run_random_phase(70, 0, 88);
      set_alphabet(1'b1);
      run_random_phase(70, 25, 25);
      set_alphabet(1'b0);
   endtask

   task automatic test_backpressure_fill();
      wait_drained();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_req = 300;
      send_message(12);
      send_message(8);
      // sender waits for every character before going on
      wait_drained();
      send_message(4);
   endtask

   initial begin
      held_bytes = '0;
      held_count = '0;
      url_alphabet = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_groups();
      test_url_alphabet();
      test_random_traffic();
      test_backpressure_fill();

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_chars.size() == 0)
         $display("PASS base64_stream_encoder");
      else
         $display("FAIL base64_stream_encoder");
      $finish;
   end

endmodule
